[rtl/sorted_priority_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit assertion macros
// Shared property forms for the priority queue checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, gated by reset
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int PRIO_W  = 8;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;
    localparam int ACT_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } cell_t;

    typedef struct packed {
        cell_op_t          op;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift queue; compares against the broadcast push.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::cell_t    left,
    input  logic              left_gt,
    input  spq_pkg::cell_t    right,
    output spq_pkg::cell_t    state,
    output logic              gt
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;
    logic [spq_pkg::DATA_W-1:0] data_reg;
    logic [spq_pkg::DATA_W-1:0] data_next;

    // held entry outranks the incoming one, so it stays
    assign gt = valid_reg && (prio_reg > cmd.prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        unique case (cmd.op)
            spq_pkg::OP_PUSH:
            begin
                if (!gt)
                begin
                    if (left_gt)
                    begin
                        valid_next = 1'b1;
                        prio_next  = cmd.prio;
                        data_next  = cmd.data;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        prio_next  = left.prio;
                        data_next  = left.data;
                    end
                end
            end
            spq_pkg::OP_POP:
            begin
                valid_next = right.valid;
                prio_next  = right.prio;
                data_next  = right.data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign state.valid = valid_reg;
    assign state.prio  = prio_reg;
    assign state.data  = data_reg;

endmodule

[rtl/sorted_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  s_*     | in  | data_in[31:0] priority_in[39:32]   | action[1:0]
//  m_*     | out | data_out[31:0] fill_count[36:32]   | status[1:0]
//
//  One word per cycle while the output register is empty or being drained: every
//  cell compares its priority with the pushed one in parallel and shifts toward its neighbor in the same cycle.
//  The result of each accepted word is registered in the output register.
//  s_tready stays high while the output register is empty or being drained.
//  Reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_in[31:0], priority_in[39:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_out[31:0], fill_count[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

`include "sorted_priority_queue_unit_macros.svh"

    localparam int DEPTH = spq_pkg::DEPTH;

    spq_pkg::cell_t             cells [DEPTH];
    spq_pkg::cell_t             lefts [DEPTH];
    spq_pkg::cell_t             rights [DEPTH];
    logic [DEPTH-1:0]           gts;
    logic [DEPTH-1:0]           left_gts;
    logic [DEPTH-1:0]           valid_vec;
    spq_pkg::cell_cmd_t         cmd;

    logic                       s_fire;
    logic                       full;
    logic                       empty;
    spq_pkg::action_t           action;

    logic [spq_pkg::CNT_W-1:0]  count_reg;
    logic [spq_pkg::CNT_W-1:0]  count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [spq_pkg::STAT_W-1:0] out_status_reg;
    logic [spq_pkg::STAT_W-1:0] out_status_next;
    logic [spq_pkg::DATA_W-1:0] out_data_reg;
    logic [spq_pkg::DATA_W-1:0] out_data_next;
    logic [spq_pkg::FILL_W-1:0] out_fill_reg;
    logic [spq_pkg::FILL_W-1:0] out_fill_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign action   = spq_pkg::action_t'(s_tuser);
    assign full     = cells[DEPTH-1].valid;
    assign empty    = !cells[0].valid;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lefts[gi]    = '0;
                assign left_gts[gi] = 1'b1;
            end
            else
            begin : g_mid
                assign lefts[gi]    = cells[gi-1];
                assign left_gts[gi] = gts[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign rights[gi] = '0;
            end
            else
            begin : g_inner
                assign rights[gi] = cells[gi+1];
            end
            assign valid_vec[gi] = cells[gi].valid;

            spq_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (lefts[gi]),
                .left_gt (left_gts[gi]),
                .right   (rights[gi]),
                .state   (cells[gi]),
                .gt      (gts[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cmd.op          = spq_pkg::OP_HOLD;
        cmd.prio        = s_tdata[32 +: spq_pkg::PRIO_W];
        cmd.data        = s_tdata[31:0];
        count_next      = count_reg;
        out_status_next = spq_pkg::ST_OK;
        out_data_next   = '0;
        unique case (action)
            spq_pkg::ACT_PUSH:
            begin
                if (full)
                begin
                    out_status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.op     = s_fire ? spq_pkg::OP_PUSH : spq_pkg::OP_HOLD;
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                end
            end
            spq_pkg::ACT_POP:
            begin
                if (empty)
                begin
                    out_status_next = spq_pkg::ST_EMPTY;
                    out_data_next   = '1;
                end
                else
                begin
                    cmd.op        = s_fire ? spq_pkg::OP_POP : spq_pkg::OP_HOLD;
                    count_next    = count_reg - spq_pkg::CNT_W'(1);
                    out_data_next = cells[0].data;
                end
            end
            spq_pkg::ACT_PEEK:
            begin
                if (empty)
                begin
                    out_status_next = spq_pkg::ST_EMPTY;
                    out_data_next   = '1;
                end
                else
                begin
                    out_data_next = cells[0].data;
                end
            end
            default:
            begin
            end
        endcase
        out_fill_next = spq_pkg::FILL_W'(count_next);
        if (!s_fire)
        begin
            count_next = count_reg;
        end
        out_valid_next = s_fire || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_fill_reg, out_data_reg};

    `SPQ_ASSERT_IMPL(a_count_matches_cells, 1'b1, $countones(valid_vec) == count_reg, "count differs from occupied cells")
    `SPQ_ASSERT_IMPL(a_cells_packed, 1'b1, ((valid_vec + DEPTH'(1)) & valid_vec) == '0, "occupied cells not packed at head")
    `SPQ_ASSERT_NEXT(a_push_grows, s_fire && action == spq_pkg::ACT_PUSH && !full, count_reg == $past(count_reg) + spq_pkg::CNT_W'(1), "push did not add an entry")
    `SPQ_ASSERT_NEXT(a_stall_holds, out_valid_reg && !m_tready, out_valid_reg && $stable(m_tdata), "result lost under stall")

endmodule

[sim/sorted_priority_queue_unit_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Drives push, pop, peek and unused-code words into the queue and checks every
// result word against a sorted-queue predictor held in the bench. The bench
// varies sender bursts and receiver stalls, and holds the receiver off once
// for a long stretch so that the input is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;

    typedef logic [spq_pkg::ACT_W-1:0]  act_t;
    typedef logic [spq_pkg::DATA_W-1:0] word_t;
    typedef logic [spq_pkg::PRIO_W-1:0] prio_t;
    typedef logic [spq_pkg::FILL_W-1:0] fill_t;

    localparam act_t ACT_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 664;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        spq_pkg::status_t status;
        word_t            data;
        fill_t            fill;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_in[31:0], priority_in[39:32]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // data_out[31:0], fill_count[36:32], zero pad
    logic [1:0]  m_tuser;   // status[1:0]

    word_t         held_data[$];
    prio_t         held_prio[$];
    queue_result_t pending_results[$];

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int hold_len = 0;
    int n_push = 0;
    int n_pop = 0;
    int n_peek = 0;
    int n_none = 0;
    int n_dropped = 0;
    int n_empty = 0;
    int max_fill = 0;
    int input_stalls = 0;

    sorted_priority_queue_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (s_tvalid && !s_tready)
            input_stalls <= input_stalls + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sorted insert ahead of equal or lower priority; one result per word
    task automatic predict_queue_op(input act_t act,
                                    input word_t d,
                                    input prio_t p);
        queue_result_t r;
        int pos;
        begin
            r.status = spq_pkg::ST_OK;
            r.data = '0;
            case (act)
                spq_pkg::ACT_PUSH:
                begin
                    n_push++;
                    if (held_data.size() >= spq_pkg::DEPTH)
                    begin
                        r.status = spq_pkg::ST_FULL;
                        n_dropped++;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < held_prio.size() && held_prio[pos] > p)
                            pos++;
                        held_data.insert(pos, d);
                        held_prio.insert(pos, p);
                    end
                end
                spq_pkg::ACT_POP:
                begin
                    n_pop++;
                    if (held_data.size() == 0)
                    begin
                        r.status = spq_pkg::ST_EMPTY;
                        r.data = '1;
                        n_empty++;
                    end
                    else
                    begin
                        r.data = held_data.pop_front();
                        void'(held_prio.pop_front());
                    end
                end
                spq_pkg::ACT_PEEK:
                begin
                    n_peek++;
                    if (held_data.size() == 0)
                    begin
                        r.status = spq_pkg::ST_EMPTY;
                        r.data = '1;
                        n_empty++;
                    end
                    else
                        r.data = held_data[0];
                end
                default:
                    n_none++;
            endcase
            r.fill = fill_t'(held_data.size());
            if (held_data.size() > max_fill)
                max_fill = held_data.size();
            pending_results.push_back(r);
        end
    endtask

    task automatic send_word(input act_t act,
                             input word_t d,
                             input prio_t p);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left--;
            @(negedge clk);
            s_tvalid = 1'b1;
            s_tdata = {p, d};
            s_tuser = act;
            do @(posedge clk); while (!s_tready);
            predict_queue_op(act, d, p);
        end
    endtask

    function automatic prio_t pick_prio();
        case ($urandom_range(0, 3))
            0: return prio_t'($urandom_range(0, 3));
            1: return prio_t'($urandom_range(0, 255));
            2: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            default: return prio_t'($urandom_range(100, 103));
        endcase
    endfunction

    function automatic act_t pick_action(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return ACT_NONE;
        if (roll < 12)
            return spq_pkg::ACT_PEEK;
        if (roll < 12 + push_pct * 88 / 100)
            return spq_pkg::ACT_PUSH;
        return spq_pkg::ACT_POP;
    endfunction

    // receiver: stall pattern is picked anew from four modes; long hold on request
    initial
    begin
        int mode;
        int mode_left;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                m_tready = 1'b0;
                hold_len--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 70);
                end
                mode_left--;
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 1) != 0);
                    2: m_tready = ($urandom_range(0, 7) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, status %0d data %h fill %0d",
                         $time, m_tuser, m_tdata[31:0], m_tdata[36:32]);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== want.data)
                begin
                    $display("%0t: data_out expected %h actual %h",
                             $time, want.data, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[36:32] !== want.fill)
                begin
                    $display("%0t: fill_count expected %0d actual %0d",
                             $time, want.fill, m_tdata[36:32]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        begin
            send_word(spq_pkg::ACT_POP, 32'h1234_5678, 8'h00);
            send_word(spq_pkg::ACT_PEEK, 32'h0, 8'hff);
            send_word(ACT_NONE, 32'hdead_beef, 8'h5a);
            send_word(spq_pkg::ACT_PUSH, 32'h8000_0000, 8'h00);
            send_word(spq_pkg::ACT_PUSH, 32'h7fff_ffff, 8'hff);
            send_word(spq_pkg::ACT_PUSH, 32'hffff_ffff, 8'hff);
            send_word(spq_pkg::ACT_PUSH, 32'h0000_0000, 8'h80);
            send_word(spq_pkg::ACT_PUSH, 32'h0000_0005, 8'h80);
            send_word(spq_pkg::ACT_PUSH, 32'h5555_aaaa, 8'h00);
            send_word(spq_pkg::ACT_PEEK, 32'hffff_ffff, 8'h00);
            send_word(ACT_NONE, 32'h0, 8'h00);
            repeat (6) send_word(spq_pkg::ACT_POP, $urandom, pick_prio());
            send_word(spq_pkg::ACT_POP, 32'h0, 8'h00);
            send_word(spq_pkg::ACT_PEEK, 32'h0, 8'h00);
        end
    endtask

    task automatic test_full();
        begin
            repeat (spq_pkg::DEPTH + 1) send_word(spq_pkg::ACT_PUSH, $urandom, pick_prio());
            send_word(spq_pkg::ACT_PUSH, 32'hffff_ffff, 8'hff);
            send_word(spq_pkg::ACT_PEEK, 32'h0, 8'h00);
            send_word(ACT_NONE, 32'h0, 8'h00);
            repeat (spq_pkg::DEPTH + 1) send_word(spq_pkg::ACT_POP, $urandom, 8'h00);
        end
    endtask

    task automatic test_random();
        int sent;
        int phase_left;
        int push_pct;
        begin
            sent = 0;
            phase_left = 0;
            push_pct = 50;
            while (sent < RANDOM_WORDS)
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 80;
                        1: push_pct = 25;
                        default: push_pct = 50;
                    endcase
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                send_word(pick_action(push_pct), $urandom, pick_prio());
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        begin
            hold_len = HOLD_OFF_CYCLES;
            burst_left = 40;
            repeat (30) send_word(pick_action(60), $urandom, pick_prio());
            while (hold_len != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = spq_pkg::ACT_PUSH;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full();
        test_backpressure();
        test_random();

        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d push (%0d dropped full), %0d pop, %0d peek, %0d unused-code words",
                 n_push, n_dropped, n_pop, n_peek, n_none);
        $display("Empty reads %0d, peak fill %0d, input stall cycles %0d, mismatches %0d",
                 n_empty, max_fill, input_stalls, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
